/* rtl/acpe_pkg.sv */
// Shared types, constants and byte functions for the AES-128 CBC encryptor.
// No dependencies; used by acpe_round and aes128_cbc_pkcs7_encrypt_top.
package acpe_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int NUM_ROUNDS  = 10;

    typedef logic [127:0] t_block;
    typedef logic [7:0]   t_byte;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    typedef enum logic [2:0] {
        REG_KEY_UPPER = 3'd0,
        REG_KEY_LOWER = 3'd1,
        REG_IV_UPPER  = 3'd2,
        REG_IV_LOWER  = 3'd3
    } t_reg_index;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8)
    function automatic t_byte gf_double(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

/* rtl/acpe_round.sv */
// One AES-128 round plus one key-schedule step, reused for all ten rounds.
// Depends on acpe_pkg (S-box table, GF doubling).
module acpe_round (
    input  acpe_pkg::t_block i_state,
    input  acpe_pkg::t_block i_round_key,
    input  acpe_pkg::t_byte  i_rcon,
    input  logic             i_last,
    output acpe_pkg::t_block o_state,
    output acpe_pkg::t_block o_round_key
);
    import acpe_pkg::*;

    t_byte  s [16];
    t_byte  t [16];
    t_byte  m [16];
    t_block mixed;
    logic [31:0] w0, w1, w2, w3, sw, k0, k1, k2, k3;

    // Next round key from the current one
    always_comb begin
        w0 = i_round_key[127:96];
        w1 = i_round_key[95:64];
        w2 = i_round_key[63:32];
        w3 = i_round_key[31:0];
        sw = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
             ^ {i_rcon, 24'h0};
        k0 = w0 ^ sw;
        k1 = w1 ^ k0;
        k2 = w2 ^ k1;
        k3 = w3 ^ k2;
        o_round_key = {k0, k1, k2, k3};
    end

    // SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey
    always_comb begin
        t_byte a0, a1, a2, a3, all;
        for (int k = 0; k < 16; k++) begin
            s[k] = i_state[127 - 8*k -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c + r] = SBOX[s[4*((c + r) % 4) + r]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0  = t[4*c];
            a1  = t[4*c + 1];
            a2  = t[4*c + 2];
            a3  = t[4*c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            m[4*c]     = i_last ? a0 : (a0 ^ all ^ gf_double(a0 ^ a1));
            m[4*c + 1] = i_last ? a1 : (a1 ^ all ^ gf_double(a1 ^ a2));
            m[4*c + 2] = i_last ? a2 : (a2 ^ all ^ gf_double(a2 ^ a3));
            m[4*c + 3] = i_last ? a3 : (a3 ^ all ^ gf_double(a3 ^ a0));
        end
        for (int k = 0; k < 16; k++) begin
            mixed[127 - 8*k -: 8] = m[k];
        end
        o_state = mixed ^ o_round_key;
    end

endmodule

/* rtl/aes128_cbc_pkcs7_encrypt_top.sv */
// AES-128 CBC encryptor with PKCS#7 padding, top level and round sequencer.
// Depends on acpe_pkg and acpe_round.
//
// One 16-byte block is taken per input transaction while o_in_stall is low.
// The accepting cycle loads the chained block with round 0 applied. A single
// shared round unit, which also computes the next round key on the fly, then
// runs the ten rounds in ST_RUN. ST_HOLD loads the output register once the
// output is free; a stalled output holds the block there. A full final block
// yields a second output transaction (the padding block), which runs the
// rounds again. Key and IV registers must be written through the config port
// only while idle (not enforced); a new IV applies at the next message start.
module aes128_cbc_pkcs7_encrypt_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_plain_upper,
    input  logic [63:0] i_plain_lower,
    input  logic [4:0]  i_valid_bytes,
    input  logic        i_final_block,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_cipher_upper,
    output logic [63:0] o_cipher_lower,
    output logic        o_message_end
);
    import acpe_pkg::*;

    t_state r_fsm, n_fsm;
    t_block r_key, r_iv, r_chain, r_data, r_rk;
    t_byte  r_rcon;
    logic [3:0] r_round;
    logic   r_second, r_end, r_in_msg;
    logic   r_out_valid;
    t_block r_out;
    logic   r_out_end;

    t_block rnd_state, rnd_key, padded, chain_sel, pad_block;
    logic   last_round, out_free, accept;
    logic [4:0] num_valid;
    t_byte  pad_val;

    assign accept   = i_in_valid && (r_fsm == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_round = (r_round == 4'(NUM_ROUNDS));
    assign pad_block  = {BLOCK_BYTES{8'(BLOCK_BYTES)}};

    acpe_round u_round (
        .i_state     (r_data),
        .i_round_key (r_rk),
        .i_rcon      (r_rcon),
        .i_last      (last_round),
        .o_state     (rnd_state),
        .o_round_key (rnd_key)
    );

    // Apply PKCS#7 padding to the incoming block
    always_comb begin
        num_valid = (i_valid_bytes > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : i_valid_bytes;
        if (!i_final_block) begin
            num_valid = 5'(BLOCK_BYTES);
        end
        pad_val = 8'(BLOCK_BYTES) - {3'b0, num_valid};
        padded  = {i_plain_upper, i_plain_lower};
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            if (5'(k) >= num_valid) begin
                padded[127 - 8*k -: 8] = pad_val;
            end
        end
        chain_sel = r_in_msg ? r_chain : r_iv;
    end

    // Next state
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            ST_IDLE: if (accept) n_fsm = ST_RUN;
            ST_RUN:  if (last_round) n_fsm = ST_HOLD;
            ST_HOLD: if (out_free) n_fsm = r_second ? ST_RUN : ST_IDLE;
            default: n_fsm = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_stall = (r_fsm != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= ST_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_iv  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_UPPER: r_key[127:64] <= i_cfg_data;
                REG_KEY_LOWER: r_key[63:0]   <= i_cfg_data;
                REG_IV_UPPER:  r_iv[127:64]  <= i_cfg_data;
                REG_IV_LOWER:  r_iv[63:0]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Message tracking and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            if (accept) begin
                r_in_msg <= !i_final_block;
                r_second <= i_final_block && (num_valid == 5'(BLOCK_BYTES));
            end else if (r_fsm == ST_HOLD && out_free) begin
                r_second <= 1'b0;
            end
            if (r_fsm == ST_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: load, iterate rounds, hand off
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data  <= padded ^ chain_sel ^ r_key;
            r_rk    <= r_key;
            r_rcon  <= 8'h01;
            r_round <= 4'd1;
            r_end   <= i_final_block && (num_valid != 5'(BLOCK_BYTES));
        end else if (r_fsm == ST_RUN) begin
            r_data  <= rnd_state;
            r_rk    <= rnd_key;
            r_rcon  <= gf_double(r_rcon);
            r_round <= r_round + 4'd1;
        end else if (r_fsm == ST_HOLD && out_free) begin
            r_out     <= r_data;
            r_out_end <= r_end;
            r_chain   <= r_data;
            // Start the extra padding block when the final block was full
            r_data  <= pad_block ^ r_data ^ r_key;
            r_rk    <= r_key;
            r_rcon  <= 8'h01;
            r_round <= 4'd1;
            r_end   <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cipher_upper = r_out[127:64];
    assign o_cipher_lower = r_out[63:0];
    assign o_message_end  = r_out_end;

endmodule

/* bench/tb_top.sv */
// Testbench for aes128_cbc_pkcs7_encrypt_top: AES-128 CBC encryption with PKCS#7 padding.
// Depends on acpe_pkg (register indexes, S-box table) and the RTL top level.
`timescale 1ns / 1ps

class cipher_scoreboard;
    logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
    logic [63:0] chain_hi, chain_lo;
    logic [31:0] rk [44];
    bit          mid_message;
    logic [128:0] pending_blocks [$];
    int          mismatches;

    function new();
        key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
        chain_hi = '0; chain_lo = '0;
        mid_message = 0;
        mismatches = 0;
        expand_round_keys();
    endfunction

    function automatic logic [7:0] xtime(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_bytes32(logic [31:0] w);
        return {acpe_pkg::SBOX[w[31:24]], acpe_pkg::SBOX[w[23:16]],
                acpe_pkg::SBOX[w[15:8]], acpe_pkg::SBOX[w[7:0]]};
    endfunction

    function void expand_round_keys();
        logic [7:0]  rcon;
        logic [31:0] t;
        rcon = 8'h01;
        rk[0] = key_hi[63:32]; rk[1] = key_hi[31:0];
        rk[2] = key_lo[63:32]; rk[3] = key_lo[31:0];
        for (int i = 4; i < 44; i++) begin
            t = rk[i-1];
            if (i % 4 == 0) begin
                t = sub_bytes32({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = xtime(rcon);
            end
            rk[i] = rk[i-4] ^ t;
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
        case (idx)
            acpe_pkg::REG_KEY_UPPER: begin key_hi = v; expand_round_keys(); end
            acpe_pkg::REG_KEY_LOWER: begin key_lo = v; expand_round_keys(); end
            acpe_pkg::REG_IV_UPPER:  iv_hi = v;
            acpe_pkg::REG_IV_LOWER:  iv_lo = v;
            default: ;
        endcase
    endfunction

    // Byte 0 sits in bits 127:120, state column c holds bytes 4c..4c+3
    function logic [127:0] aes_encrypt(logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
        for (int rd = 0; rd <= 10; rd++) begin
            if (rd > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int q = 0; q < 4; q++)
                        t[4*c+q] = acpe_pkg::SBOX[s[4*((c+q)&3)+q]];
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    if (rd == 10) begin
                        s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
                    end else begin
                        all = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                        s[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                        s[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                        s[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++)
                    s[4*c+q] ^= rk[4*rd+c][31-8*q -: 8];
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
        return r;
    endfunction

    function void chain_block(logic [127:0] blk, bit last);
        logic [127:0] ct;
        ct = aes_encrypt(blk ^ {chain_hi, chain_lo});
        {chain_hi, chain_lo} = ct;
        pending_blocks.push_back({last, ct});
    endfunction

    // Note one accepted plaintext transaction and queue its ciphertext blocks
    function void note_plaintext(logic [63:0] pu, logic [63:0] pl, logic [4:0] nb, bit fin);
        logic [127:0] blk;
        int n;
        if (!mid_message) begin chain_hi = iv_hi; chain_lo = iv_lo; end
        blk = {pu, pl};
        n = 16;
        if (fin) begin
            n = (nb > 16) ? 16 : nb;
            for (int i = n; i < 16; i++) blk[127-8*i -: 8] = 8'(16 - n);
        end
        mid_message = !fin;
        if (fin && n == 16) begin
            chain_block(blk, 0);
            chain_block({16{8'h10}}, 1);
        end else
            chain_block(blk, fin);
    endfunction

    function void check_cipher(logic [63:0] cu, logic [63:0] cl, logic me);
        logic [128:0] e;
        if (pending_blocks.size() == 0) begin
            $error("unexpected ciphertext %h_%h", cu, cl);
            mismatches++;
            return;
        end
        e = pending_blocks.pop_front();
        if (cu !== e[127:64]) begin
            $error("cipher_upper expected %h actual %h", e[127:64], cu); mismatches++;
        end
        if (cl !== e[63:0]) begin
            $error("cipher_lower expected %h actual %h", e[63:0], cl); mismatches++;
        end
        if (me !== e[128]) begin
            $error("message_end expected %0d actual %0d", e[128], me); mismatches++;
        end
    endfunction
endclass

module tb_top;
    import acpe_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk, rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid, in_stall;
    logic [63:0] plain_upper, plain_lower;
    logic [4:0]  valid_bytes;
    logic        final_block;
    logic        out_valid, out_stall;
    logic [63:0] cipher_upper, cipher_lower;
    logic        message_end;

    cipher_scoreboard sb;
    int  cycle_count;
    bit  gaps_on;        // random idling enabled
    int  hold_off;       // receiver hold-off length, cycles

    aes128_cbc_pkcs7_encrypt_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_plain_upper(plain_upper), .i_plain_lower(plain_lower),
        .i_valid_bytes(valid_bytes), .i_final_block(final_block),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_cipher_upper(cipher_upper), .o_cipher_lower(cipher_lower),
        .o_message_end(message_end)
    );

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Count cycles and end the run on a hang
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** aes128_cbc_pkcs7_encrypt_top: FAILED **");
            $finish;
        end
    end

    // Check each accepted ciphertext transaction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_cipher(cipher_upper, cipher_lower, message_end);
    end

    // Drive receiver stall: random gaps, plus a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) out_stall <= 0;
        else if (hold_off > 0) begin
            out_stall <= 1;
            hold_off <= hold_off - 1;
        end else
            out_stall <= gaps_on ? ($urandom_range(99) < 27) : 1'b0;
    end

    // Write one register, then drop the write enable before the next write
    task automatic write_cfg(logic [2:0] idx, logic [63:0] v);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // Offer one plaintext transaction and hold it until accepted
    task automatic send_block(logic [63:0] pu, logic [63:0] pl, logic [4:0] nb, bit fin);
        while (gaps_on && $urandom_range(99) < 27) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        plain_upper <= pu; plain_lower <= pl;
        valid_bytes <= nb; final_block <= fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_plaintext(pu, pl, nb, fin);
    endtask

    task automatic go_idle();
        in_valid <= 0;
        while (sb.pending_blocks.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random message: mostly short, with a random final byte count
    task automatic send_message();
        int len;
        logic [4:0] nb;
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
        for (int k = 1; k <= len; k++) begin
            nb = $urandom_range(31);
            if (k == len && $urandom_range(3) == 0) nb = 16;
            send_block(rand64(), rand64(), nb, k == len);
        end
    endtask

    initial begin
        logic [63:0] setting [4];
        sb = new();
        cycle_count = 0; gaps_on = 0; hold_off = 0;
        rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
        in_valid = 0; plain_upper = '0; plain_lower = '0;
        valid_bytes = '0; final_block = 0; out_stall = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        repeat (5) @(posedge clk);

        // Directed: reset key and IV, field extremes and padding cases
        send_block('0, '0, 5'd0, 1);                    // empty final block
        send_block('1, '1, 5'd16, 1);                   // full final, extra pad block
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd31, 1); // above 16
        send_block('1, '0, 5'd1, 0);                    // count ignored mid-message
        send_block('0, '1, 5'd15, 1);
        go_idle();
        write_cfg(REG_KEY_UPPER, 64'h000102030405060f);
        write_cfg(REG_KEY_LOWER, 64'h08090a0b0c0d0e0f);
        write_cfg(REG_IV_UPPER, '1);
        write_cfg(REG_IV_LOWER, 64'h5555aaaa5555aaaa);
        write_cfg(3'd7, '1);                            // unknown index, no effect
        for (int nb = 0; nb <= 17; nb++)
            send_block(rand64(), rand64(), 5'(nb), nb[0]);
        send_block(rand64(), rand64(), 5'd16, 1);
        go_idle();

        // Random phases with varied key and IV settings
        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < 4; r++)
                case (ph % 3)
                    0: setting[r] = rand64();
                    1: setting[r] = (ph == 1) ? '0 : rand64();
                    default: setting[r] = '1;
                endcase
            for (int r = 0; r < 4; r++) write_cfg(3'(r), setting[r]);
            gaps_on = (ph != 2);
            if (ph == 4) hold_off = 600;                // fill up and back-press
            for (int m = 0; m < 53; m++) begin
                send_message();
                // IV change mid-run applies at next message start
                if (m == 30 && ph == 5) begin
                    go_idle();
                    write_cfg(REG_IV_UPPER, rand64());
                end
            end
            go_idle();
        end

        if (sb.mismatches == 0)
            $display("** aes128_cbc_pkcs7_encrypt_top: PASSED **");
        else
            $display("** aes128_cbc_pkcs7_encrypt_top: FAILED **");
        $finish;
    end
endmodule
